### rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared definitions for the text console
// Screen geometry, field widths, codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_COPY,
    S_DRAIN,
    S_ZERO,
    S_FILL,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUT,
    MEM_FILL,
    MEM_ZERO,
    MEM_READ,
    MEM_COPY
  } mem_op_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_ADVANCE,
    CUR_NEWLINE,
    CUR_HOME
  } cur_op_t;

  typedef struct packed {
    action_t           action;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_col_out;
    logic              scrolled;
  } result_t;

  typedef struct packed {
    logic    latch_item;
    logic    cnt_clr;
    logic    cnt_inc;
    mem_op_t mem_op;
    logic    fill_reset;
    cur_op_t cur_op;
    logic    set_scroll;
    logic    cap_cell;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    is_newline;
    logic    at_last_col;
    logic    at_last_row;
    logic    rd_in_range;
    logic    cnt_last;
    logic    cnt_last_copy;
    logic    out_free;
  } status_t;

endpackage

### rtl/tcc_if.sv
// ----------------------------------------------------------------------------
// tcc_if: handshake channels of the text console
// Input item channel, result channel and color register write channel.
// ----------------------------------------------------------------------------
interface tcc_in_if
  import tcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, action, char_code, read_row, read_col, input ready);
  modport sink   (input valid, action, char_code, read_row, read_col, output ready);
endinterface

interface tcc_out_if
  import tcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_data;
  logic [ROW_W-1:0]  cursor_row_out;
  logic [COL_W-1:0]  cursor_col_out;
  logic              scrolled;

  modport source (output valid, cell_data, cursor_row_out, cursor_col_out, scrolled,
                  input ready);
  modport sink   (input valid, cell_data, cursor_row_out, cursor_col_out, scrolled,
                  output ready);
endinterface

interface tcc_cfg_if
  import tcc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/tcc_ram.sv
// ----------------------------------------------------------------------------
// tcc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_ctrl: text console controller
// Sequences each word through execute, memory sweeps and result delivery.
// ----------------------------------------------------------------------------
module tcc_ctrl
  import tcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  logic need_scroll;
  logic need_read;
  logic done_now;

  assign need_scroll = (status.action == ACT_PUT) &&
                       (status.is_newline || status.at_last_col) && status.at_last_row;
  assign need_read   = (status.action == ACT_READ) && status.rd_in_range;
  assign done_now    = !need_scroll && !need_read && (status.action != ACT_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (status.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority if (need_scroll) state_nxt = S_COPY;
        else if (status.action == ACT_CLEAR) state_nxt = S_FILL;
        else if (need_read) state_nxt = S_RD_WAIT;
        else if (status.out_free) state_nxt = S_IDLE;
        else state_nxt = S_DONE;
      end
      S_RD_WAIT: state_nxt = S_DONE;
      S_COPY: begin
        if (status.cnt_last_copy) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_ZERO;
      S_ZERO: begin
        if (status.cnt_last) state_nxt = S_DONE;
      end
      S_FILL: begin
        if (status.cnt_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.mem_op     = MEM_FILL;
        cmd.fill_reset = 1'b1;
        cmd.cnt_inc    = 1'b1;
      end
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_item = in_valid;
        cmd.cnt_clr    = in_valid;
      end
      S_EXEC: begin
        unique case (status.action)
          ACT_PUT: begin
            if (status.is_newline) begin
              cmd.cur_op = CUR_NEWLINE;
            end else begin
              cmd.mem_op = MEM_PUT;
              cmd.cur_op = status.at_last_col ? CUR_NEWLINE : CUR_ADVANCE;
            end
            cmd.set_scroll = need_scroll;
          end
          ACT_CLEAR: cmd.cur_op = CUR_HOME;
          ACT_READ: begin
            if (status.rd_in_range) cmd.mem_op = MEM_READ;
          end
          ACT_NOP: cmd.cur_op = CUR_HOLD;
          default: cmd.cur_op = CUR_HOLD;
        endcase
        cmd.load_out = done_now && status.out_free;
      end
      S_RD_WAIT: cmd.cap_cell = 1'b1;
      S_COPY: begin
        cmd.mem_op  = MEM_COPY;
        cmd.cnt_inc = 1'b1;
      end
      S_DRAIN: cmd.mem_op = MEM_NONE;
      S_ZERO: begin
        cmd.mem_op  = MEM_ZERO;
        cmd.cnt_inc = 1'b1;
      end
      S_FILL: begin
        cmd.mem_op  = MEM_FILL;
        cmd.cnt_inc = 1'b1;
      end
      S_DONE: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

  // The cursor sits on the last row for the whole of a scroll.
  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> status.at_last_row)
    else $error("scroll running with cursor off the last row");

  // The bottom row is cleared only after the copy has drained.
  a_zero_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ZERO) && ($past(state_r) != S_ZERO) |-> ($past(state_r) == S_DRAIN))
    else $error("bottom row clear entered without draining the copy");

  // A word is taken only while the controller is idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("input ready outside the idle state");

endmodule

### rtl/tcc_dp.sv
// ----------------------------------------------------------------------------
// tcc_dp: text console datapath
// Screen memory, cursor, sweep counter, color register and result register.
// ----------------------------------------------------------------------------
module tcc_dp
  import tcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  item_t              item,
  input  logic               cfg_we,
  input  logic [COLOR_W-1:0] cfg_data,
  output result_t            out_data,
  output logic               out_valid,
  input  logic               out_ready
);

  logic [COLOR_W-1:0] text_color_r;
  logic [ROW_W-1:0]   cursor_row_r, cursor_row_nxt;
  logic [COL_W-1:0]   cursor_col_r, cursor_col_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               copy_pend_r;
  logic [ADDR_W-1:0]  copy_waddr_r;
  item_t              item_r;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic               scrolled_r, scrolled_nxt;
  result_t            out_r;
  logic               out_valid_r, out_valid_nxt;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;
  logic [ADDR_W-1:0]  cur_idx;
  logic [ADDR_W-1:0]  rd_idx;
  logic [CNT_W-1:0]   copy_src;
  logic [COLOR_W-1:0] fill_color;

  assign cur_idx  = ADDR_W'(cursor_row_r) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col_r);
  assign rd_idx   = ADDR_W'(item_r.read_row) * ADDR_W'(COLUMNS) + ADDR_W'(item_r.read_col);
  assign copy_src = cnt_r + CNT_W'(COLUMNS);
  assign fill_color = cmd.fill_reset ? RESET_COLOR : text_color_r;

  // Memory port selection. A copy write lands in the cycle after its read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[ADDR_W-1:0];
    mem_wdata = '0;
    mem_raddr = copy_src[ADDR_W-1:0];
    if (copy_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = copy_waddr_r;
      mem_wdata = mem_rdata;
    end
    unique case (cmd.mem_op)
      MEM_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cur_idx;
        mem_wdata = {text_color_r, item_r.char_code};
      end
      MEM_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {fill_color, SPACE_CODE};
      end
      MEM_ZERO: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      MEM_READ: mem_raddr = rd_idx;
      MEM_COPY: mem_raddr = copy_src[ADDR_W-1:0];
      MEM_NONE: mem_raddr = copy_src[ADDR_W-1:0];
      default:  mem_raddr = copy_src[ADDR_W-1:0];
    endcase
  end

  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    cursor_row_nxt = cursor_row_r;
    cursor_col_nxt = cursor_col_r;
    unique case (cmd.cur_op)
      CUR_HOLD: cursor_col_nxt = cursor_col_r;
      CUR_ADVANCE: cursor_col_nxt = cursor_col_r + COL_W'(1);
      CUR_NEWLINE: begin
        cursor_col_nxt = '0;
        if (!status.at_last_row) cursor_row_nxt = cursor_row_r + ROW_W'(1);
      end
      CUR_HOME: begin
        cursor_col_nxt = '0;
        cursor_row_nxt = '0;
      end
      default: cursor_col_nxt = cursor_col_r;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    cell_nxt     = cell_r;
    scrolled_nxt = scrolled_r;
    if (cmd.latch_item) begin
      cell_nxt     = '0;
      scrolled_nxt = 1'b0;
    end else begin
      if (cmd.cap_cell) cell_nxt = mem_rdata;
      if (cmd.set_scroll) scrolled_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
      cursor_row_r <= '0;
      cursor_col_r <= '0;
      cnt_r        <= '0;
      copy_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) text_color_r <= cfg_data;
      cursor_row_r <= cursor_row_nxt;
      cursor_col_r <= cursor_col_nxt;
      cnt_r        <= cnt_nxt;
      copy_pend_r  <= (cmd.mem_op == MEM_COPY);
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_waddr_r <= cnt_r[ADDR_W-1:0];
    cell_r       <= cell_nxt;
    scrolled_r   <= scrolled_nxt;
    if (cmd.latch_item) item_r <= item;
    if (cmd.load_out) begin
      out_r <= '{cell_data:      cell_nxt,
                 cursor_row_out: cursor_row_nxt,
                 cursor_col_out: cursor_col_nxt,
                 scrolled:       scrolled_nxt};
    end
  end

  assign status.action        = item_r.action;
  assign status.is_newline    = (item_r.char_code == NEWLINE_CODE);
  assign status.at_last_col   = (cursor_col_r == COL_W'(COLUMNS - 1));
  assign status.at_last_row   = (cursor_row_r == ROW_W'(ROWS - 1));
  assign status.rd_in_range   = (32'(item_r.read_row) < 32'(ROWS)) &&
                                (32'(item_r.read_col) < 32'(COLUMNS));
  assign status.cnt_last      = (cnt_r == CNT_W'(CELLS - 1));
  assign status.cnt_last_copy = (cnt_r == CNT_W'(CELLS - COLUMNS - 1));
  assign status.out_free      = !out_valid_r || out_ready;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // A result is never loaded over one that has not been taken.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  // A pending copy write owns the write port.
  a_copy_port: assert property (@(posedge clk) disable iff (!rst_n)
    copy_pend_r |-> ((cmd.mem_op == MEM_COPY) || (cmd.mem_op == MEM_NONE)))
    else $error("write port conflict with pending copy");

  // The cursor always stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cursor_row_r) < 32'(ROWS)) && (32'(cursor_col_r) < 32'(COLUMNS)))
    else $error("cursor left the screen");

endmodule

### rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: character-cell text console with cursor
// Put character, newline with scroll, clear screen and cell read-back.
// ----------------------------------------------------------------------------
// After reset the block fills all ROWS*COLUMNS cells (2000 here) of the
// screen memory with spaces in color 0x0F and accepts no word until that is
// done; color writes are taken at any time. The block works on one word at a
// time through a single-port-write screen RAM. A printable character or a
// newline that does not scroll, a no-op and an off-screen read finish in the
// execute state. A cell read waits on the registered RAM read, then the
// result is loaded. A clear writes one cell per cycle, and a scroll copies
// every cell below the top row one row up through the RAM read port, one per
// cycle, then zeroes the bottom row. A finished result waits in an output
// register, so the next word can be accepted while it is still pending; that
// word then holds until the register has been taken.
module text_console_cursor_scroll
  import tcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tcc_in_if.sink    in_ch,
  tcc_out_if.source out_ch,
  tcc_cfg_if.sink   cfg_ch
);

  cmd_t    cmd;
  status_t status;
  item_t   item;
  result_t out_data;
  logic    in_rdy;
  logic    out_vld;

  assign item = '{action:    action_t'(in_ch.action),
                  char_code: in_ch.char_code,
                  read_row:  in_ch.read_row,
                  read_col:  in_ch.read_col};

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .status   (status),
    .cmd      (cmd)
  );

  tcc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .item      (item),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_data  (out_data),
    .out_valid (out_vld),
    .out_ready (out_ch.ready)
  );

  assign out_ch.valid          = out_vld;
  assign out_ch.cell_data      = out_data.cell_data;
  assign out_ch.cursor_row_out = out_data.cursor_row_out;
  assign out_ch.cursor_col_out = out_data.cursor_col_out;
  assign out_ch.scrolled       = out_data.scrolled;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the text console with cursor and scroll
// Drives words on the input channel and writes the color register while the
// console is idle. A local model of the screen memory and cursor predicts
// every result, and each result is checked field by field in arrival order.
// Directed words cover the reset screen, field and color extremes, the
// bottom-row cases and one long hold-off on the result side. Random text,
// reads, newlines and noise follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import tcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_WORDS   = 1380;
  localparam int COLOR_PERIOD   = 300;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  tcc_in_if  in_ch();
  tcc_out_if out_ch();
  tcc_cfg_if cfg_ch();

  text_console_cursor_scroll DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Model of the console: screen memory, cursor and text color.
  logic [CELL_W-1:0]  screen_model [CELLS];
  int                 row_m;
  int                 col_m;
  logic [COLOR_W-1:0] color_m;

  result_t pending_results [$];

  int  errors;
  int  reports;
  int  results_seen;
  int  words_sent;
  int  reads_sent;
  int  clears_sent;
  int  scrolls_seen;
  int  color_writes;
  int  idle_cycles;
  bit  no_idle;
  bit  hold_req;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAR_W-1:0] text_char();
    int r;
    r = $urandom_range(0, 254);
    if (r >= NEWLINE_CODE) r++;
    return r[CHAR_W-1:0];
  endfunction

  task automatic advance_row(output logic sc);
    row_m++;
    if (row_m >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = '0;
      row_m = ROWS - 1;
      sc = 1'b1;
    end else begin
      sc = 1'b0;
    end
  endtask

  task automatic console_predict(input action_t act, input logic [CHAR_W-1:0] ch,
                                 input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                                 output result_t res);
    logic sc;
    sc  = 1'b0;
    res = '0;
    case (act)
      ACT_PUT: begin
        if (ch == NEWLINE_CODE) begin
          col_m = 0;
          advance_row(sc);
        end else begin
          screen_model[row_m * COLUMNS + col_m] = {color_m, ch};
          col_m++;
          if (col_m >= COLUMNS) begin
            col_m = 0;
            advance_row(sc);
          end
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = {color_m, SPACE_CODE};
        row_m = 0;
        col_m = 0;
      end
      ACT_READ: begin
        if (rr < ROWS && rc < COLUMNS) res.cell_data = screen_model[rr * COLUMNS + rc];
      end
      default: ;
    endcase
    res.cursor_row_out = row_m[ROW_W-1:0];
    res.cursor_col_out = col_m[COL_W-1:0];
    res.scrolled       = sc;
  endtask

  // Valid is only lowered when a gap follows, so back-to-back words keep it high.
  task automatic send_word(input action_t act, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
    int      gap;
    result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.char_code <= ch;
    in_ch.read_row  <= rr;
    in_ch.read_col  <= rc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    console_predict(act, ch, rr, rc, res);
    pending_results.push_back(res);
    words_sent++;
    if (act == ACT_READ) reads_sent++;
    if (act == ACT_CLEAR) clears_sent++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_word(ACT_PUT, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
  endtask

  task automatic read_cell(input int r, input int c);
    send_word(ACT_READ, CHAR_W'($urandom_range(0, 255)), ROW_W'(r), COL_W'(c));
  endtask

  task automatic clear_screen();
    send_word(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 31)),
              COL_W'($urandom_range(0, 127)));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_color(input logic [COLOR_W-1:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    color_m = value;
    color_writes++;
  endtask

  task automatic test_reset_state();
    read_cell(0, 0);
    read_cell(ROWS - 1, COLUMNS - 1);
    read_cell(13, 41);
    put_char(8'h48);
    put_char(8'h69);
    read_cell(0, 0);
    read_cell(0, 1);
  endtask

  task automatic test_field_extremes();
    put_char(8'h00);
    put_char(8'hFF);
    put_char(SPACE_CODE);
    send_word(ACT_NOP, 8'h00, 5'h00, 7'h00);
    send_word(ACT_NOP, 8'hFF, 5'h1F, 7'h7F);
    read_cell(ROWS, 0);
    read_cell(0, COLUMNS);
    read_cell(31, 127);
    read_cell(ROWS - 1, COLUMNS);
    read_cell(0, 3);
    read_cell(0, 4);
  endtask

  task automatic test_color_extremes();
    write_color(8'h00);
    clear_screen();
    put_char(8'h41);
    read_cell(0, 0);
    read_cell(0, 1);
    write_color(8'hFF);
    put_char(8'h42);
    read_cell(0, 1);
    clear_screen();
    read_cell(ROWS - 1, COLUMNS - 1);
    write_color(8'h5A);
    put_char(text_char());
    read_cell(0, 0);
  endtask

  task automatic test_bottom_edges();
    clear_screen();
    put_char(8'h2A);
    repeat (ROWS - 1) put_char(NEWLINE_CODE);
    // A newline on the last row scrolls and leaves the cursor there.
    put_char(NEWLINE_CODE);
    read_cell(ROWS - 1, 0);
    read_cell(ROWS - 1, COLUMNS - 1);
    read_cell(ROWS - 2, 5);
    repeat (COLUMNS - 1) put_char(text_char());
    // The last cell is written, then the cursor wraps and the screen scrolls.
    put_char(text_char());
    read_cell(ROWS - 2, COLUMNS - 1);
    read_cell(ROWS - 2, 0);
    read_cell(ROWS - 1, 0);
    put_char(NEWLINE_CODE);
    clear_screen();
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    hold_req = 1'b1;
    no_idle  = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
      else put_char(text_char());
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic(input int budget);
    int start;
    int next_color;
    int r;
    int n;
    int back;
    int rr;
    start      = words_sent;
    next_color = COLOR_PERIOD;
    while (words_sent - start < budget) begin
      if (words_sent - start >= next_color) begin
        write_color(COLOR_W'($urandom_range(0, 255)));
        next_color += COLOR_PERIOD;
      end
      no_idle = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 30);
        repeat (n) put_char(text_char());
        if ($urandom_range(0, 9) < 7) put_char(NEWLINE_CODE);
      end else if (r < 68) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 4) != 0) begin
            // Aim at rows that hold recent text.
            back = $urandom_range(0, 3);
            rr   = row_m - back;
            if (rr < 0) rr = 0;
            read_cell(rr, $urandom_range(0, COLUMNS - 1));
          end else begin
            read_cell($urandom_range(0, 31), $urandom_range(0, 127));
          end
        end
      end else if (r < 72) begin
        n = $urandom_range(1, 6);
        repeat (n) put_char(NEWLINE_CODE);
      end else if (r < 74) begin
        clear_screen();
      end else if (r < 84) begin
        n = $urandom_range(1, 3);
        repeat (n) send_word(ACT_NOP, CHAR_W'($urandom_range(0, 255)),
                             ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_word(action_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                             ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.scrolled) scrolls_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        reports++;
        if (reports <= 10) $display("unexpected result word: cell %h row %0d col %0d scr %b",
                                    out_ch.cell_data, out_ch.cursor_row_out,
                                    out_ch.cursor_col_out, out_ch.scrolled);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.cell_data !== want.cell_data ||
            out_ch.cursor_row_out !== want.cursor_row_out ||
            out_ch.cursor_col_out !== want.cursor_col_out ||
            out_ch.scrolled !== want.scrolled) begin
          errors++;
          reports++;
          if (reports <= 10)
            $display("mismatch at result %0d: cell %h/%h row %0d/%0d col %0d/%0d scr %b/%b",
                     results_seen, want.cell_data, out_ch.cell_data, want.cursor_row_out,
                     out_ch.cursor_row_out, want.cursor_col_out, out_ch.cursor_col_out,
                     want.scrolled, out_ch.scrolled);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: random ready gaps, plus one long hold-off on request.
  initial begin : receiver
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    errors       = 0;
    reports      = 0;
    results_seen = 0;
    words_sent   = 0;
    reads_sent   = 0;
    clears_sent  = 0;
    scrolls_seen = 0;
    color_writes = 0;
    idle_cycles  = 0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    for (int i = 0; i < CELLS; i++) screen_model[i] = {RESET_COLOR, SPACE_CODE};
    row_m   = 0;
    col_m   = 0;
    color_m = RESET_COLOR;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_PUT;
    in_ch.char_code <= '0;
    in_ch.read_row  <= '0;
    in_ch.read_col  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_field_extremes();
    test_color_extremes();
    test_bottom_edges();
    test_output_backpressure();
    test_random_traffic(RANDOM_WORDS);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("covered %0d words (%0d reads, %0d clears), %0d results, %0d scrolls",
             words_sent, reads_sent, clears_sent, results_seen, scrolls_seen);
    $display("%0d color writes, %0d failures", color_writes, errors);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      errors += pending_results.size();
    end
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

### sim.f
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_ram.sv
rtl/tcc_ctrl.sv
rtl/tcc_dp.sv
rtl/text_console_cursor_scroll.sv
sim/tb_top.sv
